// ===== hdl/slfp_pkg.sv =====
// Shared constants for the sync word / length field frame parser.
`timescale 1ns / 1ps

package slfp_pkg;

  // Sync word, first byte on the wire first
  localparam logic [7:0]  SyncB0 = 8'h55;
  localparam logic [7:0]  SyncB1 = 8'h66;
  localparam logic [7:0]  SyncB2 = 8'hAA;
  localparam logic [7:0]  SyncB3 = 8'hBB;
  localparam logic [23:0] SyncHead3 = {SyncB0, SyncB1, SyncB2};

  localparam logic [15:0] HeaderBytes  = 16'd10;
  localparam logic [15:0] TrailerBytes = 16'd4;

  // Header byte positions
  localparam logic [15:0] HdrControl = 16'd0;
  localparam logic [15:0] HdrLenLo   = 16'd1;
  localparam logic [15:0] HdrLenHi   = 16'd2;
  localparam logic [15:0] HdrSeqLo   = 16'd3;
  localparam logic [15:0] HdrSeqHi   = 16'd4;
  localparam logic [15:0] HdrCommand = 16'd5;

  // Register file
  localparam int unsigned AddrWidth = 4;
  localparam logic [1:0]  RegHeartbeatA = 2'd0;
  localparam logic [1:0]  RegHeartbeatB = 2'd1;
  localparam logic [1:0]  RegIgnored    = 2'd2;

  localparam logic [7:0] HeartbeatAReset = 8'h83;
  localparam logic [7:0] HeartbeatBReset = 8'h2F;
  localparam logic [7:0] IgnoredReset    = 8'h8A;

  // Result kinds
  localparam logic KindPayload = 1'b0;
  localparam logic KindFrame   = 1'b1;

  // Command classes
  localparam logic [1:0] ClassHeartbeat = 2'd0;
  localparam logic [1:0] ClassIgnored   = 2'd1;
  localparam logic [1:0] ClassUnknown   = 2'd2;

endpackage

// ===== hdl/sync_length_frame_parser.sv =====
// Sync word / length field deframer: top level with input stage, parse logic and result register.
`timescale 1ns / 1ps

// Takes one received byte per word and hunts for the sync word 55 66 AA BB,
// then captures a 10-byte little-endian header (control, length, sequence,
// command, header check), emits each payload byte with its index, captures the
// 4-byte trailer and emits one frame summary with the command classed as
// heartbeat, ignored or unknown. Check words are passed through, not verified.
// A byte is taken every clock cycle while the output is not stalled: the
// parse step is a single pass of logic between the input register and the
// result register, so a byte that causes a result is held in the input
// register and then in the result register before it shows on the output.
// Stall on the output holds the result register and, through it, the input
// register. The three command registers are written over the APB port and
// are meant to change only while the block is idle.
module sync_length_frame_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      rx_byte_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            result_kind_o,
  output logic [7:0]                      payload_byte_o,
  output logic [15:0]                     byte_index_o,
  output logic [7:0]                      control_field_o,
  output logic [15:0]                     payload_length_o,
  output logic [15:0]                     sequence_number_o,
  output logic [7:0]                      command_id_o,
  output logic [1:0]                      command_class_o,
  output logic [31:0]                     header_check_o,
  output logic [31:0]                     trailer_check_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slfp_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import slfp_pkg::*;

  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhHeader  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;
  localparam logic [1:0] PhTrailer = 2'd3;

  // ---------------------------------------------------------------- config
  logic [7:0] hb_a_q, hb_b_q, ign_q;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hb_a_q <= HeartbeatAReset;
      hb_b_q <= HeartbeatBReset;
      ign_q  <= IgnoredReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegHeartbeatA: hb_a_q <= pwdata[7:0];
        RegHeartbeatB: hb_b_q <= pwdata[7:0];
        RegIgnored:    ign_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegHeartbeatA: prdata = {24'd0, hb_a_q};
      RegHeartbeatB: prdata = {24'd0, hb_b_q};
      RegIgnored:    prdata = {24'd0, ign_q};
      default:       prdata = 32'd0;
    endcase
  end

  // ----------------------------------------------------------- input stage
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       out_valid_q;

  // the result register frees up when empty or when its word is taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // ------------------------------------------------------------ parse state
  logic [23:0] sync_win_q, sync_win_d;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] field_cnt_q, field_cnt_d;
  logic [7:0]  held_ctrl_q, held_ctrl_d;
  logic [15:0] held_len_q, held_len_d;
  logic [15:0] held_seq_q, held_seq_d;
  logic [7:0]  held_cmd_q, held_cmd_d;
  logic [31:0] held_hchk_q, held_hchk_d;
  logic [31:0] held_trl_q, held_trl_d;

  logic [15:0] cnt_inc;
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_pbyte;
  logic [15:0] res_index;
  logic        res_frame;
  logic [1:0]  cmd_class;

  assign cnt_inc = field_cnt_q + 16'd1;

  always_comb begin
    priority if (held_cmd_q == hb_a_q || held_cmd_q == hb_b_q) begin
      cmd_class = ClassHeartbeat;
    end else if (held_cmd_q == ign_q) begin
      cmd_class = ClassIgnored;
    end else begin
      cmd_class = ClassUnknown;
    end
  end

  always_comb begin
    sync_win_d  = sync_win_q;
    phase_d     = phase_q;
    field_cnt_d = field_cnt_q;
    held_ctrl_d = held_ctrl_q;
    held_len_d  = held_len_q;
    held_seq_d  = held_seq_q;
    held_cmd_d  = held_cmd_q;
    held_hchk_d = held_hchk_q;
    held_trl_d  = held_trl_q;
    res_valid   = 1'b0;
    res_kind    = KindPayload;
    res_pbyte   = 8'd0;
    res_index   = 16'd0;
    res_frame   = 1'b0;

    unique case (phase_q)
      PhHunt: begin
        if (sync_win_q == SyncHead3 && in_byte_q == SyncB3) begin
          sync_win_d  = 24'd0;
          phase_d     = PhHeader;
          field_cnt_d = 16'd0;
        end else begin
          sync_win_d = {sync_win_q[15:0], in_byte_q};
        end
      end

      PhHeader: begin
        unique case (field_cnt_q)
          HdrControl:         held_ctrl_d = in_byte_q;
          HdrLenLo, HdrLenHi: held_len_d  = {in_byte_q, held_len_q[15:8]};
          HdrSeqLo, HdrSeqHi: held_seq_d  = {in_byte_q, held_seq_q[15:8]};
          HdrCommand:         held_cmd_d  = in_byte_q;
          default:            held_hchk_d = {in_byte_q, held_hchk_q[31:8]};
        endcase
        field_cnt_d = cnt_inc;
        if (cnt_inc >= HeaderBytes) begin
          field_cnt_d = 16'd0;
          // skip straight to the trailer on an empty payload
          phase_d     = (held_len_d == 16'd0) ? PhTrailer : PhPayload;
        end
      end

      PhPayload: begin
        res_valid   = 1'b1;
        res_kind    = KindPayload;
        res_pbyte   = in_byte_q;
        res_index   = field_cnt_q;
        field_cnt_d = cnt_inc;
        if (cnt_inc == held_len_q) begin
          field_cnt_d = 16'd0;
          phase_d     = PhTrailer;
        end
      end

      PhTrailer: begin
        held_trl_d  = {in_byte_q, held_trl_q[31:8]};
        field_cnt_d = cnt_inc;
        if (cnt_inc >= TrailerBytes) begin
          field_cnt_d = 16'd0;
          phase_d     = PhHunt;
          sync_win_d  = 24'd0;
          res_valid   = 1'b1;
          res_kind    = KindFrame;
          res_frame   = 1'b1;
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_win_q  <= 24'd0;
      phase_q     <= PhHunt;
      field_cnt_q <= 16'd0;
      held_ctrl_q <= 8'd0;
      held_len_q  <= 16'd0;
      held_seq_q  <= 16'd0;
      held_cmd_q  <= 8'd0;
      held_hchk_q <= 32'd0;
      held_trl_q  <= 32'd0;
    end else if (in_valid_q && advance) begin
      sync_win_q  <= sync_win_d;
      phase_q     <= phase_d;
      field_cnt_q <= field_cnt_d;
      held_ctrl_q <= held_ctrl_d;
      held_len_q  <= held_len_d;
      held_seq_q  <= held_seq_d;
      held_cmd_q  <= held_cmd_d;
      held_hchk_q <= held_hchk_d;
      held_trl_q  <= held_trl_d;
    end
  end

  // -------------------------------------------------------- result register
  logic        res_kind_q;
  logic [7:0]  res_pbyte_q;
  logic [15:0] res_index_q;
  logic [7:0]  res_ctrl_q;
  logic [15:0] res_len_q;
  logic [15:0] res_seq_q;
  logic [7:0]  res_cmd_q;
  logic [1:0]  res_class_q;
  logic [31:0] res_hchk_q;
  logic [31:0] res_trl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && res_valid) begin
      res_kind_q  <= res_kind;
      res_pbyte_q <= res_pbyte;
      res_index_q <= res_index;
      // summary fields read as zero on a payload word
      res_ctrl_q  <= res_frame ? held_ctrl_q : 8'd0;
      res_len_q   <= res_frame ? held_len_q  : 16'd0;
      res_seq_q   <= res_frame ? held_seq_q  : 16'd0;
      res_cmd_q   <= res_frame ? held_cmd_q  : 8'd0;
      res_class_q <= res_frame ? cmd_class   : ClassHeartbeat;
      res_hchk_q  <= res_frame ? held_hchk_q : 32'd0;
      res_trl_q   <= res_frame ? held_trl_d  : 32'd0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = res_kind_q;
  assign payload_byte_o    = res_pbyte_q;
  assign byte_index_o      = res_index_q;
  assign control_field_o   = res_ctrl_q;
  assign payload_length_o  = res_len_q;
  assign sequence_number_o = res_seq_q;
  assign command_id_o      = res_cmd_q;
  assign command_class_o   = res_class_q;
  assign header_check_o    = res_hchk_q;
  assign trailer_check_o   = res_trl_q;

  // ------------------------------------------------------------- assertions
  a_hunt_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHunt |-> field_cnt_q == 16'd0)
    else $error("field counter nonzero while hunting");

  a_header_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHeader |-> field_cnt_q < HeaderBytes)
    else $error("header counter out of range");

  a_trailer_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhTrailer |-> field_cnt_q < TrailerBytes)
    else $error("trailer counter out of range");

  a_payload_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> held_len_q != 16'd0)
    else $error("payload phase entered with zero length");

  a_frame_back_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && res_kind_q == KindFrame |-> phase_q == PhHunt)
    else $error("frame summary emitted without returning to hunt");

endmodule
